/* src/sfcp_pkg.sv */
// ----------------------------------------------------------------------------
// Serial flash command planner package
// Shared constants, control word types and the microcode table of the
// command planner's sequencer.
// ----------------------------------------------------------------------------
package sfcp_pkg;

    // Field widths of the request, frame and configuration items.
    localparam int ADDR_W   = 24;
    localparam int OP_W     = 3;
    localparam int LEN_W    = 13;
    localparam int OFS_W    = 12;
    localparam int OPCODE_W = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // Defaults of the top level parameters.
    localparam int PAGE_SIZE_DEF  = 256;
    localparam int MAX_LENGTH_DEF = 4096;

    // Upper bound on frames emitted for one request.
    localparam int MAX_FRAMES = 17;
    localparam int FRAME_CNT_W = $clog2(MAX_FRAMES);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_READS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_ALT    = 8'd1;

    // Serial flash command bytes.
    localparam logic [OPCODE_W-1:0] CMD_PAGE_PROGRAM = 8'h02;
    localparam logic [OPCODE_W-1:0] CMD_READ         = 8'h03;
    localparam logic [OPCODE_W-1:0] CMD_FAST_READ    = 8'h0B;
    localparam logic [OPCODE_W-1:0] CMD_SECTOR_ERASE = 8'h20;
    localparam logic [OPCODE_W-1:0] CMD_ERASE_32K    = 8'h52;
    localparam logic [OPCODE_W-1:0] CMD_ERASE_64K    = 8'hD8;
    localparam logic [OPCODE_W-1:0] CMD_CHIP_ERASE   = 8'h60;
    localparam logic [OPCODE_W-1:0] CMD_CHIP_ERASE_A = 8'hC7;
    // Write enable and write disable, sent around a wrapped frame by the link.
    localparam logic [OPCODE_W-1:0] CMD_WRITE_ENABLE  = 8'h06;
    localparam logic [OPCODE_W-1:0] CMD_WRITE_DISABLE = 8'h04;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        REQ_READ        = 3'd0,
        REQ_FAST_READ   = 3'd1,
        REQ_PROGRAM     = 3'd2,
        REQ_SECTOR_ERASE = 3'd3,
        REQ_ERASE_32K   = 3'd4,
        REQ_ERASE_64K   = 3'd5,
        REQ_CHIP_ERASE  = 3'd6
    } t_req_op;

    // Microcode step addresses.
    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc U_FETCH    = 3'd0;
    localparam t_upc U_DISPATCH = 3'd1;
    localparam t_upc U_MOD      = 3'd2;
    localparam t_upc U_RUN      = 3'd3;
    localparam t_upc U_ONE      = 3'd4;

    // Datapath action of a step.
    typedef enum logic [2:0] {
        A_FETCH,
        A_NONE,
        A_MOD,
        A_EMIT_RUN,
        A_EMIT_ONE
    } t_act;

    // Sequencing of a step.
    typedef enum logic [0:0] {
        J_COND,
        J_MAP
    } t_jmp;

    // Condition that lets a J_COND step move on to its target.
    typedef enum logic [1:0] {
        C_IN_TAKEN,
        C_MOD_DONE,
        C_RUN_END,
        C_EMIT
    } t_cond;

    // One control word of the program.
    typedef struct packed {
        t_act  act;
        t_jmp  jmp;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic in_taken;
        logic mod_done;
        logic emit_go;
        logic run_last;
        t_upc map_upc;
    } t_ustat;

    // The program: fetch a request, branch on its kind, find the page
    // offset of its start when it is split, then emit frames.
    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        case (upc)
            U_FETCH:    w = '{act: A_FETCH,    jmp: J_COND, cond: C_IN_TAKEN,
                              target: U_DISPATCH};
            U_DISPATCH: w = '{act: A_NONE,     jmp: J_MAP,  cond: C_EMIT,
                              target: U_FETCH};
            U_MOD:      w = '{act: A_MOD,      jmp: J_COND, cond: C_MOD_DONE,
                              target: U_RUN};
            U_RUN:      w = '{act: A_EMIT_RUN, jmp: J_COND, cond: C_RUN_END,
                              target: U_FETCH};
            U_ONE:      w = '{act: A_EMIT_ONE, jmp: J_COND, cond: C_EMIT,
                              target: U_FETCH};
            default:    w = '{act: A_NONE,     jmp: J_COND, cond: C_EMIT,
                              target: U_FETCH};
        endcase
        return w;
    endfunction

endpackage

/* src/sfcp_useq.sv */
// ----------------------------------------------------------------------------
// Command planner microsequencer
// Step counter over the microcode table, with conditional and mapped jumps.
// ----------------------------------------------------------------------------
module sfcp_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfcp_pkg::t_ustat i_stat,
    output sfcp_pkg::t_uword o_uword
);
    import sfcp_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w;
    logic   cond_ok;

    // Current control word.
    assign w       = ucode(r_upc);
    assign o_uword = w;

    // Condition select.
    always_comb begin
        case (w.cond)
            C_IN_TAKEN: cond_ok = i_stat.in_taken;
            C_MOD_DONE: cond_ok = i_stat.mod_done;
            C_RUN_END:  cond_ok = i_stat.emit_go && i_stat.run_last;
            C_EMIT:     cond_ok = i_stat.emit_go;
            default:    cond_ok = 1'b0;
        endcase
    end

    // Next step address: a mapped jump takes the request's entry point, a
    // conditional step holds until its condition is met.
    always_comb begin
        case (w.jmp)
            J_MAP:   n_upc = i_stat.map_upc;
            J_COND:  n_upc = cond_ok ? w.target : r_upc;
            default: n_upc = U_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

/* src/serial_flash_command_planner.sv */
// ----------------------------------------------------------------------------
// Serial flash command planner
// Turns one memory-array request into serial flash command frame items,
// splitting page programs (and fast reads when enabled) at page boundaries.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ------------------------------
//  request   in         i_in_valid / o_in_ready    op, address, length
//  frame     out        o_out_valid / i_out_ready  opcode .. last (nine fields)
//  config    in         i_cfg_valid / o_cfg_ready  register index, write data
//
//  A request is taken in the fetch step and decoded in the next. A single
//  frame (read, unsplit fast read, erase) then follows; a zero-length read,
//  fast read or program emits no frame. A split run first finds its start
//  offset within its page, by a mask (power-of-two page size) or by a
//  reciprocal multiply and then a subtract (other page sizes), then emits one
//  frame per cycle while the output does not stall, up to 17 frames. The
//  frame output register lets the next frame be produced in the cycle the
//  waiting one is taken; a stalled output holds the sequencer. Reset is
//  synchronous, holds both ready outputs low, and clears both configuration
//  registers and the control state.
//
module serial_flash_command_planner #(
    parameter int PAGE_SIZE  = sfcp_pkg::PAGE_SIZE_DEF,
    parameter int MAX_LENGTH = sfcp_pkg::MAX_LENGTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sfcp_pkg::OP_W-1:0]         i_op,
    input  logic [sfcp_pkg::ADDR_W-1:0]       i_address,
    input  logic [sfcp_pkg::LEN_W-1:0]        i_length,
    // Frame channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sfcp_pkg::OPCODE_W-1:0]     o_opcode,
    output logic [sfcp_pkg::ADDR_W-1:0]       o_frame_address,
    output logic                              o_has_address,
    output logic                              o_dummy_bytes,
    output logic [sfcp_pkg::LEN_W-1:0]        o_data_len,
    output logic [sfcp_pkg::OFS_W-1:0]        o_data_offset,
    output logic                              o_data_from_host,
    output logic                              o_write_enable_wrap,
    output logic                              o_last,
    // Configuration channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sfcp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfcp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sfcp_pkg::*;

    // Page offset width and the shape of the page size.
    localparam int  RW        = $clog2(PAGE_SIZE);
    localparam bit  PAGE_POW2 = ((PAGE_SIZE & (PAGE_SIZE - 1)) == 0);
    localparam int  LEN_MAX   = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_LENGTH > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(MAX_LENGTH);
    localparam logic [LEN_W-1:0]  PAGE_L  = LEN_W'(PAGE_SIZE);
    localparam logic [ADDR_W-1:0] PAGE_A  = ADDR_W'(PAGE_SIZE);
    localparam logic [FRAME_CNT_W-1:0] FRAME_END = FRAME_CNT_W'(MAX_FRAMES - 1);

    // Reciprocal of the page size: floor(a * RECIP_M / 2^RECIP_S) equals
    // floor(a / PAGE_SIZE) for every address a.
    localparam int  RECIP_S = ADDR_W + RW;
    localparam int  RECIP_W = ADDR_W + 2;
    localparam int  PROD_W  = ADDR_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_S) / PAGE_SIZE) + 1);

    t_uword uw;
    t_ustat st;

    // Configuration registers.
    logic r_split_reads;
    logic r_chip_alt;

    // Request and run registers.
    logic [OP_W-1:0]        r_op;
    logic [ADDR_W-1:0]      r_addr;
    logic [LEN_W-1:0]       r_len;
    logic [ADDR_W-1:0]      r_cur;
    logic [LEN_W-1:0]       r_done;
    logic [FRAME_CNT_W-1:0] r_frames;

    // Page offset of the run start (remainder unit).
    logic [RW-1:0]          r_rem;
    logic [RW-1:0]          n_rem;
    logic [ADDR_W-1:0]      r_quot;
    logic                   r_mod_step;
    logic [PROD_W-1:0]      recip_prod;
    logic [ADDR_W-1:0]      quot;
    logic [ADDR_W-1:0]      page_base;

    // Frame output register.
    logic                   r_out_valid;
    logic [OPCODE_W-1:0]    r_opcode;
    logic [ADDR_W-1:0]      r_frame_address;
    logic                   r_has_address;
    logic                   r_dummy_bytes;
    logic [LEN_W-1:0]       r_data_len;
    logic [OFS_W-1:0]       r_data_offset;
    logic                   r_data_from_host;
    logic                   r_write_enable_wrap;
    logic                   r_last;

    // Frame being produced.
    logic [OPCODE_W-1:0]    f_opcode;
    logic [ADDR_W-1:0]      f_addr;
    logic                   f_has_addr;
    logic                   f_dummy;
    logic [LEN_W-1:0]       f_len;
    logic [OFS_W-1:0]       f_ofs;
    logic                   f_from_host;
    logic                   f_wrap;
    logic                   f_last;

    logic                   in_taken;
    logic                   emit_go;
    logic                   emitting;
    logic [LEN_W-1:0]       remain;
    logic [LEN_W-1:0]       room;
    logic [LEN_W-1:0]       chunk;
    logic                   run_last;
    logic                   is_program;
    t_upc                   map_upc;

    sfcp_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (st),
        .o_uword (uw)
    );

    // Handshakes.
    assign o_in_ready  = i_rst_n && (uw.act == A_FETCH);
    assign in_taken    = i_in_valid && o_in_ready;
    assign o_cfg_ready = i_rst_n;
    assign emit_go     = !r_out_valid || i_out_ready;
    assign emitting    = emit_go && ((uw.act == A_EMIT_RUN) || (uw.act == A_EMIT_ONE));

    // Entry point of the program for the request in hand.
    always_comb begin
        case (r_op)
            REQ_READ:         map_upc = (r_len == '0) ? U_FETCH : U_ONE;
            REQ_FAST_READ:    map_upc = (r_len == '0) ? U_FETCH
                                      : (r_split_reads ? U_MOD : U_ONE);
            REQ_PROGRAM:      map_upc = (r_len == '0) ? U_FETCH : U_MOD;
            REQ_SECTOR_ERASE: map_upc = U_ONE;
            REQ_ERASE_32K:    map_upc = U_ONE;
            REQ_ERASE_64K:    map_upc = U_ONE;
            REQ_CHIP_ERASE:   map_upc = U_ONE;
            default:          map_upc = U_FETCH;
        endcase
    end

    // Remainder of the start address by the page size. A power-of-two page
    // takes a mask. Otherwise the first step registers the quotient from a
    // reciprocal multiply and the second subtracts quotient times page size.
    assign recip_prod = PROD_W'(r_cur) * PROD_W'(RECIP_M);
    assign quot       = ADDR_W'(recip_prod >> RECIP_S);
    assign page_base  = r_quot * PAGE_A;
    always_comb begin
        if (PAGE_POW2) begin
            n_rem = r_cur[RW-1:0];
        end else begin
            n_rem = RW'(r_cur - page_base);
        end
    end

    // Chunk of the next run frame: what is left, capped at the page room.
    assign remain   = r_len - r_done;
    assign room     = PAGE_L - LEN_W'(r_rem);
    assign chunk    = (remain > room) ? room : remain;
    assign run_last = (remain <= room) || (r_frames == FRAME_END);
    assign is_program = (r_op == REQ_PROGRAM);

    assign st = '{in_taken: in_taken,
                  mod_done: PAGE_POW2 || r_mod_step,
                  emit_go:  emit_go,
                  run_last: run_last,
                  map_upc:  map_upc};

    // Frame contents for a single frame or a run frame.
    always_comb begin
        f_addr      = r_addr;
        f_has_addr  = 1'b1;
        f_dummy     = 1'b0;
        f_len       = '0;
        f_ofs       = '0;
        f_from_host = 1'b0;
        f_wrap      = 1'b1;
        f_last      = 1'b1;
        if (uw.act == A_EMIT_RUN) begin
            f_opcode    = is_program ? CMD_PAGE_PROGRAM : CMD_FAST_READ;
            f_addr      = r_cur;
            f_dummy     = !is_program;
            f_len       = chunk;
            f_ofs       = r_done[OFS_W-1:0];
            f_from_host = is_program;
            f_wrap      = is_program;
            f_last      = run_last;
        end else begin
            case (r_op)
                REQ_READ: begin
                    f_opcode = CMD_READ;
                    f_len    = r_len;
                    f_wrap   = 1'b0;
                end
                REQ_FAST_READ: begin
                    f_opcode = CMD_FAST_READ;
                    f_dummy  = 1'b1;
                    f_len    = r_len;
                    f_wrap   = 1'b0;
                end
                REQ_SECTOR_ERASE: f_opcode = CMD_SECTOR_ERASE;
                REQ_ERASE_32K:    f_opcode = CMD_ERASE_32K;
                REQ_ERASE_64K:    f_opcode = CMD_ERASE_64K;
                REQ_CHIP_ERASE: begin
                    f_opcode   = r_chip_alt ? CMD_CHIP_ERASE_A : CMD_CHIP_ERASE;
                    f_addr     = '0;
                    f_has_addr = 1'b0;
                end
                default: f_opcode = CMD_READ;
            endcase
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_reads <= 1'b0;
            r_chip_alt    <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SPLIT_READS) begin
                r_split_reads <= i_cfg_data[0];
            end
            if (i_cfg_index == CFG_CHIP_ALT) begin
                r_chip_alt <= i_cfg_data[0];
            end
        end
    end

    // Request capture and run bookkeeping.
    always_ff @(posedge i_clk) begin
        if (in_taken) begin
            r_op       <= i_op;
            r_addr     <= i_address;
            r_len      <= (i_length > LEN_CAP) ? LEN_CAP : i_length;
            r_cur      <= i_address;
            r_done     <= '0;
            r_frames   <= '0;
            r_rem      <= '0;
            r_mod_step <= 1'b0;
        end else if (uw.act == A_MOD) begin
            r_quot     <= quot;
            r_rem      <= n_rem;
            r_mod_step <= 1'b1;
        end else if (emitting && (uw.act == A_EMIT_RUN)) begin
            r_done   <= r_done + chunk;
            r_cur    <= r_cur + ADDR_W'(chunk);
            r_frames <= r_frames + FRAME_CNT_W'(1);
            // Every frame but the last ends on a page boundary.
            r_rem    <= '0;
        end
    end

    // Frame output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emitting) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emitting) begin
            r_opcode            <= f_opcode;
            r_frame_address     <= f_addr;
            r_has_address       <= f_has_addr;
            r_dummy_bytes       <= f_dummy;
            r_data_len          <= f_len;
            r_data_offset       <= f_ofs;
            r_data_from_host    <= f_from_host;
            r_write_enable_wrap <= f_wrap;
            r_last              <= f_last;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_opcode            = r_opcode;
    assign o_frame_address     = r_frame_address;
    assign o_has_address       = r_has_address;
    assign o_dummy_bytes       = r_dummy_bytes;
    assign o_data_len          = r_data_len;
    assign o_data_offset       = r_data_offset;
    assign o_data_from_host    = r_data_from_host;
    assign o_write_enable_wrap = r_write_enable_wrap;
    assign o_last              = r_last;

endmodule
